FILE: rtl/core/ksw_pkg.sv
package ksw_pkg;

    localparam int WORD_W = 16;
    localparam int KEY_W  = 20;
    localparam int SEL_W  = 2;
    localparam int SETS   = 4;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [SEL_W-1:0]  sel_t;

    // Key field positions
    localparam int KEY_PERM_LSB = 18;
    localparam int KEY_SBOX_LSB = 16;

    // Source bit for each output bit, one row per permutation select
    localparam logic [3:0] PERM_SEL [SETS][WORD_W] = '{
        '{4'd8,  4'd10, 4'd1,  4'd3,  4'd7,  4'd4,  4'd11, 4'd2,
          4'd5,  4'd15, 4'd6,  4'd0,  4'd12, 4'd13, 4'd9,  4'd14},
        '{4'd4,  4'd5,  4'd9,  4'd6,  4'd1,  4'd13, 4'd7,  4'd11,
          4'd10, 4'd0,  4'd14, 4'd12, 4'd8,  4'd15, 4'd2,  4'd3},
        '{4'd12, 4'd7,  4'd11, 4'd2,  4'd0,  4'd5,  4'd15, 4'd6,
          4'd1,  4'd8,  4'd14, 4'd4,  4'd9,  4'd13, 4'd3,  4'd10},
        '{4'd14, 4'd1,  4'd11, 4'd15, 4'd7,  4'd3,  4'd8,  4'd13,
          4'd0,  4'd4,  4'd2,  4'd12, 4'd6,  4'd10, 4'd5,  4'd9}
    };

    localparam logic [3:0] ADDR_SEL [WORD_W] = '{
        4'd0,  4'd3,  4'd7,  4'd8,  4'd12, 4'd1,  4'd6,  4'd11,
        4'd15, 4'd4,  4'd9,  4'd10, 4'd14, 4'd2,  4'd5,  4'd13
    };

    localparam logic [4:0] SUB5 [SETS][32] = '{
        '{5'd4,  5'd12, 5'd8,  5'd14, 5'd16, 5'd30, 5'd31, 5'd0,
          5'd23, 5'd29, 5'd24, 5'd21, 5'd11, 5'd22, 5'd27, 5'd5,
          5'd3,  5'd20, 5'd18, 5'd26, 5'd10, 5'd7,  5'd17, 5'd1,
          5'd28, 5'd6,  5'd15, 5'd13, 5'd2,  5'd9,  5'd25, 5'd19},
        '{5'd3,  5'd0,  5'd14, 5'd17, 5'd10, 5'd15, 5'd31, 5'd20,
          5'd13, 5'd2,  5'd29, 5'd28, 5'd9,  5'd18, 5'd25, 5'd27,
          5'd6,  5'd19, 5'd30, 5'd22, 5'd7,  5'd12, 5'd1,  5'd16,
          5'd23, 5'd11, 5'd24, 5'd4,  5'd8,  5'd26, 5'd21, 5'd5},
        '{5'd9,  5'd15, 5'd28, 5'd7,  5'd13, 5'd24, 5'd2,  5'd23,
          5'd21, 5'd1,  5'd22, 5'd16, 5'd18, 5'd8,  5'd17, 5'd31,
          5'd27, 5'd6,  5'd30, 5'd12, 5'd4,  5'd20, 5'd5,  5'd19,
          5'd0,  5'd25, 5'd3,  5'd29, 5'd10, 5'd14, 5'd11, 5'd26},
        '{5'd17, 5'd3,  5'd31, 5'd2,  5'd28, 5'd10, 5'd9,  5'd29,
          5'd6,  5'd25, 5'd24, 5'd8,  5'd13, 5'd1,  5'd19, 5'd15,
          5'd22, 5'd0,  5'd14, 5'd20, 5'd16, 5'd7,  5'd21, 5'd4,
          5'd18, 5'd26, 5'd27, 5'd5,  5'd12, 5'd23, 5'd11, 5'd30}
    };

    localparam logic [3:0] SUB4A [SETS][16] = '{
        '{4'd13, 4'd1,  4'd0,  4'd9,  4'd5,  4'd12, 4'd4,  4'd14,
          4'd3,  4'd15, 4'd2,  4'd10, 4'd11, 4'd6,  4'd8,  4'd7},
        '{4'd2,  4'd10, 4'd6,  4'd9,  4'd11, 4'd13, 4'd4,  4'd5,
          4'd3,  4'd15, 4'd7,  4'd14, 4'd12, 4'd1,  4'd0,  4'd8},
        '{4'd5,  4'd2,  4'd13, 4'd11, 4'd8,  4'd6,  4'd12, 4'd1,
          4'd4,  4'd3,  4'd0,  4'd10, 4'd14, 4'd15, 4'd7,  4'd9},
        '{4'd4,  4'd8,  4'd11, 4'd15, 4'd3,  4'd14, 4'd7,  4'd12,
          4'd1,  4'd0,  4'd9,  4'd5,  4'd6,  4'd13, 4'd2,  4'd10}
    };

    localparam logic [3:0] SUB4B [SETS][16] = '{
        '{4'd7,  4'd13, 4'd4,  4'd6,  4'd5,  4'd9,  4'd3,  4'd2,
          4'd0,  4'd15, 4'd12, 4'd10, 4'd8,  4'd11, 4'd1,  4'd14},
        '{4'd1,  4'd13, 4'd11, 4'd3,  4'd8,  4'd7,  4'd9,  4'd10,
          4'd12, 4'd15, 4'd4,  4'd14, 4'd0,  4'd5,  4'd6,  4'd2},
        '{4'd11, 4'd6,  4'd10, 4'd0,  4'd12, 4'd1,  4'd8,  4'd14,
          4'd2,  4'd9,  4'd13, 4'd3,  4'd7,  4'd4,  4'd15, 4'd5},
        '{4'd14, 4'd0,  4'd9,  4'd11, 4'd4,  4'd1,  4'd7,  4'd5,
          4'd13, 4'd6,  4'd8,  4'd12, 4'd2,  4'd3,  4'd10, 4'd15}
    };

    localparam logic [2:0] SUB3 [SETS][8] = '{
        '{3'd4, 3'd0, 3'd1, 3'd2, 3'd5, 3'd7, 3'd3, 3'd6},
        '{3'd6, 3'd5, 3'd0, 3'd3, 3'd7, 3'd1, 3'd4, 3'd2},
        '{3'd1, 3'd5, 3'd6, 3'd2, 3'd4, 3'd7, 3'd3, 3'd0},
        '{3'd2, 3'd1, 3'd0, 3'd5, 3'd4, 3'd6, 3'd7, 3'd3}
    };

    // Permute the cipher word and fold in the shuffled address
    function automatic word_t ksw_mix(word_t cw, word_t ad, sel_t psel);
        word_t r;
        r = '0;
        for (int i = 0; i < WORD_W; i++) begin
            r[i] = cw[PERM_SEL[psel][i]] ^ ad[ADDR_SEL[i]];
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/keyed_sbox_word_decrypt_top.sv
// Keyed ROM word decryptor.
// Input channel: in_valid / in_stall carry one beat of cipher_word plus its
// word_address. Output channel: out_valid / out_stall carry one beat of
// plain_word. A beat moves on a rising edge with valid high and stall low.
// The key is loaded through cfg_wr_en / cfg_wr_data (bits 19-18 permutation,
// 17-16 S-box set, 15-0 output xor); load it only while no beat is in flight.
// Pipeline: three register stages (permute+address mix, S-box lookup,
// key xor into the output register). An accepted beat moves from the
// s1 register to s2 and then to s3, and plain_word is driven straight
// from the s3 register together with out_valid.
// Throughput is one word per cycle as long as out_stall stays low.
// When the receiver stalls, the output beat holds and stages behind it fill
// up; in_stall rises only once every stage holds a beat, so up to three
// beats can sit in the pipe while the output waits.
// Reset clears all stage valid bits and the key register to zero.
module keyed_sbox_word_decrypt_top
    import ksw_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [KEY_W-1:0] cfg_wr_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [15:0]      cipher_word,
    input  logic [15:0]      word_address,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [15:0]      plain_word
);

    key_t  key_reg;
    logic  s1_valid_reg;
    logic  s2_valid_reg;
    logic  s3_valid_reg;
    word_t s1_word_reg;
    word_t s2_word_reg;
    word_t s3_word_reg;

    logic  s1_valid_next;
    logic  s2_valid_next;
    logic  s3_valid_next;
    word_t s1_word_next;
    word_t s2_word_next;
    word_t s3_word_next;

    logic  s1_load;
    logic  s2_load;
    logic  s3_load;
    word_t sbox_out;

    // A stage loads when it is empty or its contents move on
    assign s3_load  = !s3_valid_reg || !out_stall;
    assign s2_load  = !s2_valid_reg || s3_load;
    assign s1_load  = !s1_valid_reg || s2_load;
    assign in_stall = !s1_load;

    ksw_sbox u_sbox
    (
        .word_in  (s1_word_reg),
        .set_sel  (key_reg[KEY_SBOX_LSB +: SEL_W]),
        .word_out (sbox_out)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s2_valid_next = s2_valid_reg;
        s3_valid_next = s3_valid_reg;
        s1_word_next  = s1_word_reg;
        s2_word_next  = s2_word_reg;
        s3_word_next  = s3_word_reg;
        if (s1_load)
        begin
            s1_valid_next = in_valid;
            if (in_valid)
            begin
                s1_word_next = ksw_mix(cipher_word, word_address,
                                       key_reg[KEY_PERM_LSB +: SEL_W]);
            end
        end
        if (s2_load)
        begin
            s2_valid_next = s1_valid_reg;
            if (s1_valid_reg)
            begin
                s2_word_next = sbox_out;
            end
        end
        if (s3_load)
        begin
            s3_valid_next = s2_valid_reg;
            if (s2_valid_reg)
            begin
                s3_word_next = s2_word_reg ^ key_reg[WORD_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                key_reg <= cfg_wr_data;
            end
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_word_reg <= s1_word_next;
        s2_word_reg <= s2_word_next;
        s3_word_reg <= s3_word_next;
    end

    assign out_valid  = s3_valid_reg;
    assign plain_word = s3_word_reg;

endmodule

FILE: rtl/core/ksw_sbox.sv
module ksw_sbox
    import ksw_pkg::*;
(
    input  word_t word_in,
    input  sel_t  set_sel,
    output word_t word_out
);

    logic [4:0] f0;
    logic [3:0] f1;
    logic [3:0] f2;
    logic [2:0] f3;

    always_comb
    begin
        f0 = SUB5[set_sel][word_in[4:0]];
        f1 = SUB4A[set_sel][word_in[8:5]];
        f2 = SUB4B[set_sel][word_in[12:9]];
        f3 = SUB3[set_sel][word_in[15:13]];
    end

    assign word_out = {f3, f2, f1, f0};

endmodule
